[sv/weighted_adjacency_list_store_top_macros.svh]
// Assertion macros shared by the weighted adjacency list store checker.
`ifndef WEIGHTED_ADJACENCY_LIST_STORE_TOP_MACROS_SVH
`define WEIGHTED_ADJACENCY_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WALS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WALS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/wals_pkg.sv]
// Shared types and constants of the weighted adjacency list store.
package wals_pkg;

    localparam int VERTEX_BITS    = 4;
    localparam int WEIGHT_IO_BITS = 32;
    localparam int STATUS_BITS    = 2;

    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_ADD    = 1'b1;

    localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_U,
        ST_LEN_V,
        ST_SCAN,
        ST_DECIDE,
        ST_APPEND_U,
        ST_APPEND_V,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic ent_we;
        logic len_we;
    } mem_ctl_t;

endpackage

[sv/wals_req_if.sv]
// Request channel: one command item per handshake.
interface wals_req_if;
    import wals_pkg::*;

    logic                              valid;
    logic                              ready;
    logic                              command;
    logic        [VERTEX_BITS-1:0]     src_vertex;
    logic        [VERTEX_BITS-1:0]     dst_vertex;
    logic signed [WEIGHT_IO_BITS-1:0]  edge_weight;
    logic                              undirected;

    modport source (output valid, command, src_vertex, dst_vertex, edge_weight, undirected,
                    input ready);
    modport sink   (input valid, command, src_vertex, dst_vertex, edge_weight, undirected,
                    output ready);
endinterface

[sv/wals_rsp_if.sv]
// Response channel: one result item per handshake.
interface wals_rsp_if;
    import wals_pkg::*;

    logic                              valid;
    logic                              ready;
    logic        [STATUS_BITS-1:0]     status;
    logic signed [WEIGHT_IO_BITS-1:0]  weight_out;

    modport source (output valid, status, weight_out, input ready);
    modport sink   (input valid, status, weight_out, output ready);
endinterface

[sv/wals_list_mem.sv]
// Neighbour entry RAM and list length RAM with per-list valid bits.
module wals_list_mem #(
    parameter int NV          = 16,
    parameter int MAX_DEGREE  = 15,
    parameter int WEIGHT_BITS = 32,
    parameter int AW          = 8,
    parameter int VW          = 4,
    parameter int LW          = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  wals_pkg::mem_ctl_t                  ctl,
    input  logic [AW-1:0]                       ent_addr,
    input  logic [wals_pkg::VERTEX_BITS-1:0]    ent_wr_id,
    input  logic signed [WEIGHT_BITS-1:0]       ent_wr_weight,
    output logic [wals_pkg::VERTEX_BITS-1:0]    ent_rd_id,
    output logic signed [WEIGHT_BITS-1:0]       ent_rd_weight,
    input  logic [VW-1:0]                       len_addr,
    input  logic [LW-1:0]                       len_wr,
    output logic [LW-1:0]                       len_rd
);
    import wals_pkg::*;

    localparam int ENT_DEPTH = NV * MAX_DEGREE;

    logic        [VERTEX_BITS-1:0] id_ram_reg     [ENT_DEPTH];
    logic signed [WEIGHT_BITS-1:0] weight_ram_reg [ENT_DEPTH];
    logic        [LW-1:0]          len_ram_reg    [NV];
    logic        [NV-1:0]          len_vld_reg;
    logic        [LW-1:0]          len_raw_reg;
    logic                          len_rd_vld_reg;

    // entry RAM, one port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.ent_we)
        begin
            id_ram_reg[ent_addr]     <= ent_wr_id;
            weight_ram_reg[ent_addr] <= ent_wr_weight;
        end
        ent_rd_id     <= id_ram_reg[ent_addr];
        ent_rd_weight <= weight_ram_reg[ent_addr];
    end

    // length RAM
    always_ff @(posedge clk)
    begin
        if (ctl.len_we)
        begin
            len_ram_reg[len_addr] <= len_wr;
        end
        len_raw_reg <= len_ram_reg[len_addr];
    end

    // an unwritten list reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_vld_reg    <= '0;
            len_rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.len_we)
            begin
                len_vld_reg[len_addr] <= 1'b1;
            end
            len_rd_vld_reg <= len_vld_reg[len_addr];
        end
    end

    assign len_rd = len_rd_vld_reg ? len_raw_reg : '0;

endmodule

[sv/weighted_adjacency_list_store_top.sv]
// Top level: bounded weighted neighbour lists with lookup and add, one item at a time.
// Steps: after acceptance the lengths of both lists are read, the source list is scanned
// entry by entry, a miss is decided and each new entry is appended; then the result is
// loaded into the output register. A new item is taken only after that, and the loading
// waits while the previous result is still held and not taken.
// Reset: async, active low; clears sequencer, result valid, list valid bits and their read bit only.
module weighted_adjacency_list_store_top #(
    parameter int VERTICES    = 16,
    parameter int MAX_DEGREE  = 15,
    parameter int WEIGHT_BITS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    wals_req_if.sink   req,
    wals_rsp_if.source rsp
);
    import wals_pkg::*;

    // Only vertices that fit the 4-bit vertex fields can ever be named.
    localparam int NV        = (VERTICES < (1 << VERTEX_BITS)) ? VERTICES : (1 << VERTEX_BITS);
    localparam int ENT_DEPTH = NV * MAX_DEGREE;
    localparam int AW        = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;
    localparam int VW        = (NV > 1) ? $clog2(NV) : 1;
    localparam int LW        = $clog2(MAX_DEGREE + 1);

    localparam logic [LW:0]            MAX_LEN  = (LW + 1)'(MAX_DEGREE);
    localparam logic [AW-1:0]          DEG_A    = AW'(MAX_DEGREE);
    localparam logic [VERTEX_BITS:0]   NV_LIMIT = (VERTEX_BITS + 1)'(NV);

    // Sequencer
    state_t state_reg;
    state_t state_next;

    // Latched item
    logic                          cmd_reg;
    logic [VERTEX_BITS-1:0]        u_reg;
    logic [VERTEX_BITS-1:0]        v_reg;
    logic signed [WEIGHT_BITS-1:0] w_reg;
    logic                          und_reg;
    logic [AW-1:0]                 base_u_reg;
    logic [AW-1:0]                 base_v_reg;

    // Scan state
    logic [LW-1:0]                 len_u_reg;
    logic [LW-1:0]                 len_v_reg;
    logic [LW-1:0]                 idx_reg;

    // Result of the item in flight, and the output register
    logic [STATUS_BITS-1:0]        res_status_reg;
    logic [WEIGHT_IO_BITS-1:0]     res_weight_reg;
    logic                          rsp_valid_reg;
    logic [STATUS_BITS-1:0]        rsp_status_reg;
    logic [WEIGHT_IO_BITS-1:0]     rsp_weight_reg;

    // Memory side
    mem_ctl_t                      mem_ctl;
    logic [AW-1:0]                 ent_addr;
    logic [VERTEX_BITS-1:0]        ent_wr_id;
    logic [VERTEX_BITS-1:0]        ent_rd_id;
    logic signed [WEIGHT_BITS-1:0] ent_rd_weight;
    logic [VW-1:0]                 len_addr;
    logic [LW-1:0]                 len_wr;
    logic [LW-1:0]                 len_rd;

    // Helpers
    logic                          accept;
    logic                          out_free;
    logic                          u_ok;
    logic                          v_ok;
    logic                          range_bad;
    logic                          scan_hit;
    logic                          scan_more;
    logic                          self_loop;
    logic                          room;
    logic [LW-1:0]                 len_v_eff;
    logic signed [63:0]            in_w_ext;
    logic signed [63:0]            rd_w_ext;

    assign accept   = req.valid && req.ready;
    assign out_free = !rsp_valid_reg || rsp.ready;

    assign u_ok = (VERTEX_BITS + 1)'(u_reg) < NV_LIMIT;
    assign v_ok = (VERTEX_BITS + 1)'(v_reg) < NV_LIMIT;
    // a lookup from an unknown vertex is simply absent; an add needs both ends
    assign range_bad = (cmd_reg == CMD_LOOKUP) ? !u_ok : (!u_ok || !v_ok);

    assign scan_hit  = (ent_rd_id == v_reg);
    assign scan_more = ((LW + 1)'(idx_reg) + (LW + 1)'(1)) < (LW + 1)'(len_u_reg);

    // undirected self loop puts both entries in one list
    assign self_loop = und_reg && (u_reg == v_reg);
    assign room = self_loop
                ? (((LW + 1)'(len_u_reg) + (LW + 1)'(2)) <= MAX_LEN)
                : (((LW + 1)'(len_u_reg) < MAX_LEN) &&
                   (!und_reg || ((LW + 1)'(len_v_reg) < MAX_LEN)));
    assign len_v_eff = self_loop ? (len_u_reg + LW'(1)) : len_v_reg;

    // weight kept at WEIGHT_BITS, read back sign-extended and cut to the port width
    assign in_w_ext = 64'(req.edge_weight);
    assign rd_w_ext = 64'(ent_rd_weight);

    wals_list_mem #(
        .NV          (NV),
        .MAX_DEGREE  (MAX_DEGREE),
        .WEIGHT_BITS (WEIGHT_BITS),
        .AW          (AW),
        .VW          (VW),
        .LW          (LW)
    ) u_list_mem (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (mem_ctl),
        .ent_addr      (ent_addr),
        .ent_wr_id     (ent_wr_id),
        .ent_wr_weight (w_reg),
        .ent_rd_id     (ent_rd_id),
        .ent_rd_weight (ent_rd_weight),
        .len_addr      (len_addr),
        .len_wr        (len_wr),
        .len_rd        (len_rd)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LEN_U;
                end
            end
            ST_LEN_U:
            begin
                state_next = ST_LEN_V;
            end
            ST_LEN_V:
            begin
                if (range_bad)
                begin
                    state_next = ST_DONE;
                end
                else if (len_u_reg == '0)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = ST_DONE;
                end
                else if (!scan_more)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (cmd_reg == CMD_ADD && room)
                begin
                    state_next = ST_APPEND_U;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_APPEND_U:
            begin
                state_next = und_reg ? ST_APPEND_V : ST_DONE;
            end
            ST_APPEND_V:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: handshake and memory port control
    always_comb
    begin
        req.ready      = 1'b0;
        mem_ctl.ent_we = 1'b0;
        mem_ctl.len_we = 1'b0;
        ent_addr       = base_u_reg;
        ent_wr_id      = v_reg;
        len_addr       = u_reg[VW-1:0];
        len_wr         = len_u_reg + LW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                len_addr  = req.src_vertex[VW-1:0];
            end
            ST_LEN_U:
            begin
                len_addr = v_reg[VW-1:0];
            end
            ST_LEN_V:
            begin
                ent_addr = base_u_reg;
            end
            ST_SCAN:
            begin
                ent_addr = base_u_reg + AW'(idx_reg) + AW'(1);
            end
            ST_APPEND_U:
            begin
                mem_ctl.ent_we = 1'b1;
                mem_ctl.len_we = 1'b1;
                ent_addr       = base_u_reg + AW'(len_u_reg);
                ent_wr_id      = v_reg;
                len_addr       = u_reg[VW-1:0];
                len_wr         = len_u_reg + LW'(1);
            end
            ST_APPEND_V:
            begin
                mem_ctl.ent_we = 1'b1;
                mem_ctl.len_we = 1'b1;
                ent_addr       = base_v_reg + AW'(len_v_eff);
                ent_wr_id      = u_reg;
                len_addr       = v_reg[VW-1:0];
                len_wr         = len_v_eff + LW'(1);
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_reg    <= req.command;
                    u_reg      <= req.src_vertex;
                    v_reg      <= req.dst_vertex;
                    w_reg      <= in_w_ext[WEIGHT_BITS-1:0];
                    und_reg    <= req.undirected;
                    base_u_reg <= AW'(req.src_vertex[VW-1:0]) * DEG_A;
                    base_v_reg <= AW'(req.dst_vertex[VW-1:0]) * DEG_A;
                end
            end
            ST_LEN_U:
            begin
                len_u_reg <= len_rd;
            end
            ST_LEN_V:
            begin
                len_v_reg      <= len_rd;
                idx_reg        <= '0;
                res_status_reg <= (cmd_reg == CMD_LOOKUP) ? STATUS_MISS : STATUS_FULL;
                res_weight_reg <= '0;
            end
            ST_SCAN:
            begin
                if (scan_hit)
                begin
                    res_status_reg <= (cmd_reg == CMD_LOOKUP) ? STATUS_OK : STATUS_MISS;
                    res_weight_reg <= rd_w_ext[WEIGHT_IO_BITS-1:0];
                end
                idx_reg <= idx_reg + LW'(1);
            end
            ST_DECIDE:
            begin
                res_weight_reg <= '0;
                if (cmd_reg == CMD_LOOKUP)
                begin
                    res_status_reg <= STATUS_MISS;
                end
                else if (room)
                begin
                    res_status_reg <= STATUS_OK;
                end
                else
                begin
                    res_status_reg <= STATUS_FULL;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    rsp_status_reg <= res_status_reg;
                    rsp_weight_reg <= res_weight_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.weight_out = rsp_weight_reg;

endmodule

[sv/wals_checker.sv]
// Port-level checker for the weighted adjacency list store, bound to the top level.
`include "weighted_adjacency_list_store_top_macros.svh"

module wals_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 req_valid,
    input logic                                 req_ready,
    input logic                                 rsp_valid,
    input logic                                 rsp_ready,
    input logic [wals_pkg::STATUS_BITS-1:0]     rsp_status,
    input logic [wals_pkg::WEIGHT_IO_BITS-1:0]  rsp_weight_out
);
    import wals_pkg::*;

    // one item in flight: the request side closes right after an acceptance
    `WALS_ASSERT_NEXT(a_one_item, clk, rst_n, req_valid && req_ready, !req_ready, "item accepted while another is in flight")

    // a stalled result holds
    `WALS_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_weight_out), "stalled result changed")

    `WALS_ASSERT_NOW(a_status_code, clk, rst_n, rsp_valid, rsp_status == STATUS_OK || rsp_status == STATUS_MISS || rsp_status == STATUS_FULL, "undefined status code")

    // nothing written means no weight reported
    `WALS_ASSERT_NOW(a_full_no_weight, clk, rst_n, rsp_valid && rsp_status == STATUS_FULL, rsp_weight_out == '0, "weight reported with full status")

endmodule

bind weighted_adjacency_list_store_top wals_checker u_wals_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_weight_out (rsp.weight_out)
);
